FILE: hw/rtl/fcsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// FAT12 chain sector locator package
// Widths, codes and state types shared by the locator unit and its checker.
// ----------------------------------------------------------------------------
package fcsl_pkg;

   // Field widths.
   localparam int CL_W      = 12;   // cluster number and FAT entry
   localparam int POS_W     = 13;   // FAT byte position
   localparam int LS_W      = 20;   // logical sector and cylinder
   localparam int REM_W     = 14;   // divider remainder, below heads times track length
   localparam int DIV_STEPS = 20;   // one quotient bit per step
   localparam int DIV_CNT_W = 5;

   // FAT12 constants.
   localparam logic [CL_W-1:0] END_MARK    = 12'hFF8;
   localparam logic [CL_W-1:0] FAT12_LIMIT = 12'd4087;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_START   = 2'd1,
      CMD_ADVANCE = 2'd2
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_CHAIN  = 2'd1,
      STAT_TOO_LARGE = 2'd2,
      STAT_BELOW_TWO = 2'd3
   } status_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_SPC = 3'd0,
      REG_FDS = 3'd1,
      REG_SPT = 3'd2,
      REG_HC  = 3'd3,
      REG_VOL = 3'd4
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_RD_LO,
      ST_RD_HI,
      ST_DIV_CYL,
      ST_DIV_SEC,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/fcsl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcsl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fat12_chain_sector_locator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// FAT12 chain sector locator unit
// Holds a FAT12 table in RAM, walks a cluster chain one request at a time and
// gives each cluster's first logical sector and its cylinder, head and sector.
// ----------------------------------------------------------------------------
//  Channel  | Ports                      | Handshake
//  ---------+----------------------------+------------------------------------
//  request  | req_valid, req_stall, req_* | taken when valid and not stall
//  result   | rsp_valid, rsp_stall, rsp_* | taken when valid and not stall
//  config   | psel..pready               | write in APB access, pready high
//
// A FAT byte write finishes in the idle state. A start or an advance passes through
// checks, two FAT byte reads on the single RAM read port and two 20-step divides
// before its result is loaded; the next request is taken back in the idle state.
// Error results skip the reads and divides; a no-chain advance also skips the checks.
// Reset is synchronous; it resets the chain state, configuration and result valid, not the FAT RAM.
// A stalled result holds; the next request is taken and waits in its last state.
// ----------------------------------------------------------------------------
module fat12_chain_sector_locator_unit
   import fcsl_pkg::*;
#(
   parameter int FAT_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [12:0] req_byte_index,
   input  wire logic [7:0]  req_fat_byte,
   input  wire logic [11:0] req_start_cluster,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_current_cluster,
   output logic [11:0]      rsp_next_cluster,
   output logic             rsp_last,
   output logic [11:0]      rsp_page_index,
   output logic [19:0]      rsp_cluster_lba,
   output logic [19:0]      rsp_cylinder,
   output logic [7:0]       rsp_head,
   output logic [5:0]       rsp_sector,
   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int FAT_ADDR_W = $clog2(FAT_BYTES);

   // Configuration registers.
   logic [7:0]  spc_ff, spc_in;
   logic [15:0] fds_ff, fds_in;
   logic [5:0]  spt_ff, spt_in;
   logic [7:0]  hc_ff, hc_in;
   logic [15:0] vol_ff, vol_in;

   // Sequencer and chain state.
   state_type        state_ff, state_in;
   logic [CL_W-1:0]  cl_ff, cl_in;
   logic [CL_W-1:0]  chain_cluster_ff, chain_cluster_in;
   logic             chain_active_ff, chain_active_in;
   logic [CL_W-1:0]  page_count_ff, page_count_in;

   // Working registers of one locate.
   logic [POS_W-1:0] pos_hi_ff, pos_hi_in;
   logic             lo_oob_ff, lo_oob_in;
   logic             hi_oob_ff, hi_oob_in;
   logic [7:0]       lo_byte_ff, lo_byte_in;
   status_type       res_status_ff, res_status_in;
   logic [CL_W-1:0]  res_next_ff, res_next_in;
   logic             res_last_ff, res_last_in;
   logic [CL_W-1:0]  res_page_ff, res_page_in;
   logic [LS_W-1:0]  ls_ff, ls_in;
   logic [LS_W-1:0]  cyl_ff, cyl_in;

   // Shared divider.
   logic [REM_W-1:0]     div_rem_ff, div_rem_in;
   logic [LS_W-1:0]      div_quo_ff, div_quo_in;
   logic [REM_W-1:0]     div_dvs_ff, div_dvs_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [CL_W-1:0]  rsp_cur_ff, rsp_cur_in;
   logic [CL_W-1:0]  rsp_next_ff, rsp_next_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [CL_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [LS_W-1:0]  rsp_ls_ff, rsp_ls_in;
   logic [LS_W-1:0]  rsp_cyl_ff, rsp_cyl_in;
   logic [7:0]       rsp_head_ff, rsp_head_in;
   logic [5:0]       rsp_sector_ff, rsp_sector_in;

   // RAM ports.
   logic                  ram_wr_en;
   logic [FAT_ADDR_W-1:0] ram_rd_addr;
   logic [7:0]            ram_rd_data;

   // Combinational helpers.
   logic                 req_accept;
   logic                 cfg_write;
   reg_index_type        cfg_index;
   logic [7:0]           spc_nz, hc_nz;
   logic [5:0]           spt_nz;
   logic [CL_W+1:0]      cl_x3;
   logic [POS_W-1:0]     pos_lo;
   logic [LS_W-1:0]      vol_limit;
   logic [7:0]           hi_byte;
   logic [15:0]          fat_pair;
   logic [CL_W-1:0]      fat_entry;
   logic [REM_W:0]       div_shift;
   logic                 div_ge;
   logic [REM_W-1:0]     step_rem;
   logic [LS_W-1:0]      step_quo;
   logic                 out_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign cfg_write  = psel && penable && pwrite;
   assign cfg_index  = reg_index_type'(paddr[4:2]);
   assign pready     = 1'b1;

   // A zero divisor counts as one.
   assign spc_nz = (spc_ff == 8'd0) ? 8'd1 : spc_ff;
   assign spt_nz = (spt_ff == 6'd0) ? 6'd1 : spt_ff;
   assign hc_nz  = (hc_ff  == 8'd0) ? 8'd1 : hc_ff;

   // FAT byte position of the current cluster's entry: cluster * 3 / 2.
   assign cl_x3  = {2'b00, cl_ff} + {1'b0, cl_ff, 1'b0};
   assign pos_lo = cl_x3[POS_W:1];

   // The volume is too large for FAT12 when volume / spc reaches the limit.
   assign vol_limit = LS_W'({8'd0, FAT12_LIMIT} * {12'd0, spc_nz});

   // Assemble the 12-bit entry from the byte pair; bytes outside read zero.
   assign hi_byte   = hi_oob_ff ? 8'd0 : ram_rd_data;
   assign fat_pair  = {hi_byte, lo_byte_ff};
   assign fat_entry = cl_ff[0] ? fat_pair[15:4] : fat_pair[CL_W-1:0];

   // One restoring divider step.
   assign div_shift = {div_rem_ff, div_quo_ff[LS_W-1]};
   assign div_ge    = (div_shift >= {1'b0, div_dvs_ff});
   assign step_rem  = div_ge ? REM_W'(div_shift - {1'b0, div_dvs_ff}) : div_shift[REM_W-1:0];
   assign step_quo  = {div_quo_ff[LS_W-2:0], div_ge};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // FAT store.
   assign ram_wr_en = req_accept && (req_command == CMD_WRITE)
                      && ({1'b0, req_byte_index} < (POS_W+1)'(FAT_BYTES));

   fcsl_ram #(
      .WIDTH (8),
      .DEPTH (FAT_BYTES)
   ) u_fat_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_byte_index[FAT_ADDR_W-1:0]),
      .wr_data (req_fat_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration write and read.
   always_comb begin
      spc_in = spc_ff;
      fds_in = fds_ff;
      spt_in = spt_ff;
      hc_in  = hc_ff;
      vol_in = vol_ff;
      prdata = 32'd0;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_SPC: spc_in = pwdata[7:0];
            REG_FDS: fds_in = pwdata[15:0];
            REG_SPT: spt_in = pwdata[5:0];
            REG_HC:  hc_in  = pwdata[7:0];
            REG_VOL: vol_in = pwdata[15:0];
            default: ;
         endcase
      end
      unique case (cfg_index)
         REG_SPC: prdata = {24'd0, spc_ff};
         REG_FDS: prdata = {16'd0, fds_ff};
         REG_SPT: prdata = {26'd0, spt_ff};
         REG_HC:  prdata = {24'd0, hc_ff};
         REG_VOL: prdata = {16'd0, vol_ff};
         default: prdata = 32'd0;
      endcase
   end

   // Sequencer: next state, working registers and output register.
   always_comb begin
      state_in         = state_ff;
      cl_in            = cl_ff;
      chain_cluster_in = chain_cluster_ff;
      chain_active_in  = chain_active_ff;
      page_count_in    = page_count_ff;
      pos_hi_in        = pos_hi_ff;
      lo_oob_in        = lo_oob_ff;
      hi_oob_in        = hi_oob_ff;
      lo_byte_in       = lo_byte_ff;
      res_status_in    = res_status_ff;
      res_next_in      = res_next_ff;
      res_last_in      = res_last_ff;
      res_page_in      = res_page_ff;
      ls_in            = ls_ff;
      cyl_in           = cyl_ff;
      div_rem_in       = div_rem_ff;
      div_quo_in       = div_quo_ff;
      div_dvs_in       = div_dvs_ff;
      div_cnt_in       = div_cnt_ff;
      ram_rd_addr      = pos_lo[FAT_ADDR_W-1:0];

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_cur_in    = rsp_cur_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_ls_in     = rsp_ls_ff;
      rsp_cyl_in    = rsp_cyl_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_sector_in = rsp_sector_ff;

      unique case (state_ff)
         // Take a request; a FAT byte write finishes here.
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_command)
                  CMD_START: begin
                     page_count_in = '0;
                     cl_in         = req_start_cluster;
                     state_in      = ST_LOCATE;
                  end
                  CMD_ADVANCE: begin
                     if (chain_active_ff) begin
                        cl_in    = chain_cluster_ff;
                        state_in = ST_LOCATE;
                     end else begin
                        cl_in         = '0;
                        res_status_in = STAT_NO_CHAIN;
                        state_in      = ST_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Check the volume and the cluster, then read the low FAT byte.
         ST_LOCATE: begin
            pos_hi_in = pos_lo + POS_W'(1);
            lo_oob_in = ({1'b0, pos_lo} >= (POS_W+1)'(FAT_BYTES));
            hi_oob_in = ({1'b0, pos_lo} + (POS_W+1)'(1) >= (POS_W+1)'(FAT_BYTES));
            if ({4'd0, vol_ff} >= vol_limit) begin
               res_status_in   = STAT_TOO_LARGE;
               chain_active_in = 1'b0;
               state_in        = ST_DONE;
            end else if (cl_ff < CL_W'(2)) begin
               res_status_in   = STAT_BELOW_TWO;
               chain_active_in = 1'b0;
               state_in        = ST_DONE;
            end else begin
               res_status_in = STAT_OK;
               state_in      = ST_RD_LO;
            end
         end

         // Low byte arrives; read the high byte and form the logical sector.
         ST_RD_LO: begin
            ram_rd_addr = pos_hi_ff[FAT_ADDR_W-1:0];
            lo_byte_in  = lo_oob_ff ? 8'd0 : ram_rd_data;
            ls_in       = LS_W'({8'd0, cl_ff - CL_W'(2)} * {12'd0, spc_ff})
                          + {4'd0, fds_ff};
            state_in    = ST_RD_HI;
         end

         // High byte arrives; update the chain and start the cylinder divide.
         ST_RD_HI: begin
            res_next_in      = fat_entry;
            res_last_in      = (fat_entry >= END_MARK);
            res_page_in      = page_count_ff;
            page_count_in    = page_count_ff + CL_W'(1);
            chain_cluster_in = fat_entry;
            chain_active_in  = (fat_entry < END_MARK);
            div_rem_in       = '0;
            div_quo_in       = ls_ff;
            div_dvs_in       = REM_W'({6'd0, hc_nz} * {8'd0, spt_nz});
            div_cnt_in       = '0;
            state_in         = ST_DIV_CYL;
         end

         // Logical sector / sectors per cylinder.
         ST_DIV_CYL: begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            div_rem_in = step_rem;
            div_quo_in = step_quo;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               cyl_in     = step_quo;
               div_rem_in = '0;
               div_quo_in = {{(LS_W-REM_W){1'b0}}, step_rem};
               div_dvs_in = {{(REM_W-6){1'b0}}, spt_nz};
               div_cnt_in = '0;
               state_in   = ST_DIV_SEC;
            end
         end

         // Remainder / sectors per track gives head and sector.
         ST_DIV_SEC: begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            div_rem_in = step_rem;
            div_quo_in = step_quo;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end

         // Load the result once the output register is free.
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cur_in    = cl_ff;
               if (res_status_ff == STAT_OK) begin
                  rsp_next_in   = res_next_ff;
                  rsp_last_in   = res_last_ff;
                  rsp_page_in   = res_page_ff;
                  rsp_ls_in     = ls_ff;
                  rsp_cyl_in    = cyl_ff;
                  rsp_head_in   = div_quo_ff[7:0];
                  rsp_sector_in = div_rem_ff[5:0] + 6'd1;
               end else begin
                  rsp_next_in   = '0;
                  rsp_last_in   = 1'b0;
                  rsp_page_in   = '0;
                  rsp_ls_in     = '0;
                  rsp_cyl_in    = '0;
                  rsp_head_in   = '0;
                  rsp_sector_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         chain_cluster_ff <= '0;
         chain_active_ff  <= 1'b0;
         page_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         spc_ff           <= 8'd1;
         fds_ff           <= 16'd33;
         spt_ff           <= 6'd18;
         hc_ff            <= 8'd2;
         vol_ff           <= 16'd2880;
      end else begin
         state_ff         <= state_in;
         chain_cluster_ff <= chain_cluster_in;
         chain_active_ff  <= chain_active_in;
         page_count_ff    <= page_count_in;
         rsp_valid_ff     <= rsp_valid_in;
         spc_ff           <= spc_in;
         fds_ff           <= fds_in;
         spt_ff           <= spt_in;
         hc_ff            <= hc_in;
         vol_ff           <= vol_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cl_ff         <= cl_in;
      pos_hi_ff     <= pos_hi_in;
      lo_oob_ff     <= lo_oob_in;
      hi_oob_ff     <= hi_oob_in;
      lo_byte_ff    <= lo_byte_in;
      res_status_ff <= res_status_in;
      res_next_ff   <= res_next_in;
      res_last_ff   <= res_last_in;
      res_page_ff   <= res_page_in;
      ls_ff         <= ls_in;
      cyl_ff        <= cyl_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_dvs_ff    <= div_dvs_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_ls_ff     <= rsp_ls_in;
      rsp_cyl_ff    <= rsp_cyl_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_sector_ff <= rsp_sector_in;
   end

   // Result ports.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_current_cluster = rsp_cur_ff;
   assign rsp_next_cluster    = rsp_next_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_page_index      = rsp_page_ff;
   assign rsp_cluster_lba     = rsp_ls_ff;
   assign rsp_cylinder        = rsp_cyl_ff;
   assign rsp_head            = rsp_head_ff;
   assign rsp_sector          = rsp_sector_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fcsl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// FAT12 chain sector locator checker
// Port-level assertions on the result channel, bound to the locator unit.
// ----------------------------------------------------------------------------
module fcsl_checker
   import fcsl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [11:0] rsp_current_cluster,
   input wire logic [11:0] rsp_next_cluster,
   input wire logic        rsp_last,
   input wire logic [11:0] rsp_page_index,
   input wire logic [19:0] rsp_cluster_lba,
   input wire logic [19:0] rsp_cylinder,
   input wire logic [7:0]  rsp_head,
   input wire logic [5:0]  rsp_sector
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its status, cluster and logical sector.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_current_cluster) && $stable(rsp_cluster_lba))
      else $error("stalled result changed");

   // An error result carries only its status and cluster.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_next_cluster == 12'd0)
         && !rsp_last && (rsp_page_index == 12'd0) && (rsp_cluster_lba == 20'd0)
         && (rsp_cylinder == 20'd0) && (rsp_head == 8'd0) && (rsp_sector == 6'd0))
      else $error("error result with nonzero fields");

   // A good result has a one-based sector and a cluster of at least two, and last marks an end-of-chain entry.
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_OK) |-> (rsp_sector != 6'd0)
         && (rsp_last == (rsp_next_cluster >= END_MARK)) && (rsp_current_cluster >= 12'd2))
      else $error("inconsistent good result");

endmodule

bind fat12_chain_sector_locator_unit fcsl_checker u_fcsl_checker (.*);
`default_nettype wire
